// ===== sv/png_scanline_unfilter_top_assert.svh =====
// Assertion macros shared by the scanline unfilter modules.
`ifndef PNG_SCANLINE_UNFILTER_TOP_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_TOP_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define PNGU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define PNGU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pngu_pkg.sv =====
package pngu_pkg;

  // Row filter codes.
  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  // Configuration register indexes.
  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_BPP   = 1'b1;

  localparam int WIDTH_W = 13;
  localparam int BPP_W   = 3;

  // Result queue.
  localparam int OUT_DEPTH = 4;
  localparam int PTR_W     = 2;
  localparam int CNT_W     = 3;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [15:0] len_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       row_end;
    logic       bad_filter;
  } out_item_t;

  typedef struct packed {
    logic [2:0] filter;
    logic [7:0] raw;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
  } pred_in_t;

endpackage

// ===== sv/pngu_predict.sv =====
module pngu_predict (
  input  pngu_pkg::pred_in_t pin,
  output logic [7:0]         value
);

  logic        [8:0] avg_sum;
  logic signed [9:0] sa, sb, sc;
  logic signed [9:0] da, db, dc;
  logic        [9:0] pa, pb, pc;
  logic        [7:0] paeth;
  logic        [7:0] pred;

  always_comb begin
    sa = 10'(pin.a);
    sb = 10'(pin.b);
    sc = 10'(pin.c);
    // With p = a + b - c: |p - a| = |b - c|, |p - b| = |a - c|, |p - c| = |a + b - 2c|.
    da = sb - sc;
    db = sa - sc;
    dc = sa + sb - sc - sc;
    pa = (da < 0) ? 10'(-da) : 10'(da);
    pb = (db < 0) ? 10'(-db) : 10'(db);
    pc = (dc < 0) ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      paeth = pin.a;
    end else if (pb <= pc) begin
      paeth = pin.b;
    end else begin
      paeth = pin.c;
    end
    avg_sum = 9'(pin.a) + 9'(pin.b);
  end

  always_comb begin
    unique case (pin.filter)
      pngu_pkg::FILT_NONE:  pred = 8'd0;
      pngu_pkg::FILT_SUB:   pred = pin.a;
      pngu_pkg::FILT_UP:    pred = pin.b;
      pngu_pkg::FILT_AVG:   pred = avg_sum[8:1];
      pngu_pkg::FILT_PAETH: pred = paeth;
      default:              pred = 8'd0;
    endcase
  end

  assign value = pin.raw + pred;

endmodule

// ===== sv/pngu_out_fifo.sv =====
`include "png_scanline_unfilter_top_assert.svh"

module pngu_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pngu_pkg::out_item_t push_item,
  input  logic                pop,
  output pngu_pkg::out_item_t head_item,
  output pngu_pkg::cnt_t      count
);

  pngu_pkg::out_item_t             entries [pngu_pkg::OUT_DEPTH];
  logic [pngu_pkg::PTR_W-1:0]      wr_ptr;
  logic [pngu_pkg::PTR_W-1:0]      rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head_item = entries[rd_ptr];

  `PNGU_ASSERT_IMPL(a_fifo_no_overflow, clk, rst, push, count < pngu_pkg::CNT_W'(pngu_pkg::OUT_DEPTH) || pop, "result queue overflow")
  `PNGU_ASSERT_IMPL(a_fifo_no_underflow, clk, rst, pop, count != '0, "result queue underflow")
  `PNGU_ASSERT_NEXT(a_fifo_count_hold, clk, rst, push && pop, count == $past(count), "queue count moved on push with pop")

endmodule

// ===== sv/png_scanline_unfilter_top.sv =====
// PNG scanline unfilter for 8-bit RGB and RGBA images.
// The slave stream carries the inflated, still filtered image one byte per word:
// s_tdata holds the byte and s_tuser flags the first byte of a new image. The first
// byte of every row is its filter type; it gives no output word. Each further byte of
// the row gives one reconstructed byte on the master stream, with m_tlast on the last
// byte of the row. A filter type above 4 gives a single word with m_tuser set and
// data zero, after which input is consumed and dropped until the next image start.
// Width and bytes per pixel are written through cfg_we/cfg_index/cfg_data between
// words; out-of-range values are clamped.
// An accepted byte is registered in the reconstruction stage, then pushed into the
// result queue. Throughput is one byte per cycle while the queue has room, set by
// the line store (one read and one write each cycle) and the single 8-bit
// reconstruction add that feeds the next byte. A four-entry result queue lets input
// keep flowing while the receiver stalls; s_tready drops once queued words plus the
// one in flight fill it and picks up again as soon as words are taken. Reset clears
// all control state and the queue. The line store itself is not swept: a fill mark
// makes entries not yet written since reset read as zero, so no clearing pass is needed.
`include "png_scanline_unfilter_top_assert.svh"

module png_scanline_unfilter_top #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_BPP   = 4
) (
  input  logic        clk,
  input  logic        rst,
  // Slave stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] stream_byte
  input  logic [0:0]  s_tuser,    // [0] image_start
  // Master stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [7:0] pixel_byte
  output logic        m_tlast,    // row_end
  output logic [0:0]  m_tuser,    // [0] bad_filter
  // Configuration writes.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);

  // The register field is 13 bits, so widths beyond its range can never be used.
  localparam int FIELD_MAX = (1 << pngu_pkg::WIDTH_W) - 1;
  localparam int EFF_WIDTH = (MAX_WIDTH < FIELD_MAX) ? MAX_WIDTH : FIELD_MAX;
  localparam int ROW_BYTES = EFF_WIDTH * MAX_BPP;
  localparam int AW        = $clog2(ROW_BYTES);
  localparam int FW        = $clog2(ROW_BYTES + 1);

  // Configuration registers.
  logic [pngu_pkg::WIDTH_W-1:0] width_reg;
  logic [pngu_pkg::BPP_W-1:0]   bpp_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg <= pngu_pkg::WIDTH_W'(1);
      bpp_reg   <= pngu_pkg::BPP_W'(4);
    end else if (cfg_we) begin
      unique case (cfg_index)
        pngu_pkg::REG_WIDTH: width_reg <= cfg_data;
        pngu_pkg::REG_BPP:   bpp_reg   <= cfg_data[pngu_pkg::BPP_W-1:0];
        default:             width_reg <= width_reg;
      endcase
    end
  end

  // Clamped geometry and row length.
  logic [pngu_pkg::WIDTH_W-1:0] w_eff;
  logic [pngu_pkg::BPP_W-1:0]   bpp_eff;
  pngu_pkg::len_t               row_len;

  always_comb begin
    if (width_reg == '0) begin
      w_eff = pngu_pkg::WIDTH_W'(1);
    end else if (32'(width_reg) > EFF_WIDTH) begin
      w_eff = pngu_pkg::WIDTH_W'(EFF_WIDTH);
    end else begin
      w_eff = width_reg;
    end
    if (bpp_reg < pngu_pkg::BPP_W'(3)) begin
      bpp_eff = pngu_pkg::BPP_W'(3);
    end else if (32'(bpp_reg) > MAX_BPP) begin
      bpp_eff = pngu_pkg::BPP_W'(MAX_BPP);
    end else begin
      bpp_eff = bpp_reg;
    end
    row_len = pngu_pkg::len_t'(w_eff) * pngu_pkg::len_t'(bpp_eff);
  end

  // Row state. col_mod3 tracks the column modulo three so that the pixel slot is
  // known for either pixel size without a divider.
  logic [AW-1:0] col;
  logic [1:0]    col_mod3;
  logic [2:0]    row_filter;
  logic          first_row;
  logic          expect_filter;
  logic          halted;

  logic [AW-1:0] col_next;
  logic [1:0]    col_mod3_next;
  logic [2:0]    row_filter_next;
  logic          first_row_next;
  logic          expect_filter_next;
  logic          halted_next;

  // Reconstruction stage: one byte whose upper neighbor is being read from the store.
  logic          s1_valid;
  logic          s1_err;
  logic [2:0]    s1_filter;
  logic [7:0]    s1_byte;
  logic [1:0]    s1_slot;
  logic          s1_left_ok;
  logic          s1_up_ok;
  logic          s1_last;
  logic [AW-1:0] s1_addr;

  logic          s1_valid_next;
  logic          s1_err_next;

  // Line store and neighbor bytes.
  logic [7:0]    line_mem [ROW_BYTES];
  logic [7:0]    rd_data;
  logic          rd_en;
  logic          wr_en;
  logic [FW-1:0] fill;
  logic [7:0]    left_bytes       [4];
  logic [7:0]    upper_left_bytes [4];

  // Handshake and result queue.
  logic           accept;
  logic           pop;
  pngu_pkg::cnt_t q_count;
  pngu_pkg::out_item_t push_item;
  pngu_pkg::out_item_t head_item;

  // Input side as seen after an image start has taken effect.
  logic          start;
  logic [AW-1:0] col_eff;
  logic [1:0]    col_mod3_eff;
  logic          first_eff;
  logic          expect_eff;
  logic          halted_eff;
  logic [1:0]    slot;
  logic          left_ok;
  logic          up_ok;
  logic          last;
  pngu_pkg::len_t col_plus;

  // Admit a word only if the queue can take every result already in flight.
  assign s_tready = (q_count + pngu_pkg::cnt_t'(s1_valid)) < pngu_pkg::cnt_t'(pngu_pkg::OUT_DEPTH);
  assign accept   = s_tvalid && s_tready;
  assign start    = s_tuser[0];

  always_comb begin
    col_eff      = start ? '0 : col;
    col_mod3_eff = start ? 2'd0 : col_mod3;
    first_eff    = first_row || start;
    expect_eff   = expect_filter || start;
    halted_eff   = halted && !start;
    slot         = (bpp_eff == pngu_pkg::BPP_W'(3)) ? col_mod3_eff : col_eff[1:0];
    left_ok      = pngu_pkg::len_t'(col_eff) >= pngu_pkg::len_t'(bpp_eff);
    // Entries at or above the fill mark were never written since reset and read as zero.
    up_ok        = !first_eff && (FW'(col_eff) < fill);
    col_plus     = pngu_pkg::len_t'(col_eff) + pngu_pkg::len_t'(1);
    last         = col_plus >= row_len;
  end

  always_comb begin
    col_next           = col;
    col_mod3_next      = col_mod3;
    row_filter_next    = row_filter;
    first_row_next     = first_row;
    expect_filter_next = expect_filter;
    halted_next        = halted;
    s1_valid_next      = 1'b0;
    s1_err_next        = 1'b0;
    rd_en              = 1'b0;
    if (accept) begin
      col_next           = col_eff;
      col_mod3_next      = col_mod3_eff;
      first_row_next     = first_eff;
      expect_filter_next = expect_eff;
      halted_next        = halted_eff;
      priority if (halted_eff) begin
        // Dropped without a result.
      end else if (expect_eff) begin
        if (s_tdata > 8'(pngu_pkg::FILT_PAETH)) begin
          halted_next   = 1'b1;
          s1_valid_next = 1'b1;
          s1_err_next   = 1'b1;
        end else begin
          row_filter_next    = s_tdata[2:0];
          col_next           = '0;
          col_mod3_next      = 2'd0;
          expect_filter_next = 1'b0;
        end
      end else begin
        s1_valid_next = 1'b1;
        rd_en         = 1'b1;
        if (last) begin
          col_next           = '0;
          col_mod3_next      = 2'd0;
          expect_filter_next = 1'b1;
          first_row_next     = 1'b0;
        end else begin
          col_next      = col_plus[AW-1:0];
          col_mod3_next = (col_mod3_eff == 2'd2) ? 2'd0 : col_mod3_eff + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col           <= '0;
      col_mod3      <= 2'd0;
      row_filter    <= pngu_pkg::FILT_NONE;
      first_row     <= 1'b1;
      expect_filter <= 1'b1;
      halted        <= 1'b0;
      s1_valid      <= 1'b0;
    end else begin
      col           <= col_next;
      col_mod3      <= col_mod3_next;
      row_filter    <= row_filter_next;
      first_row     <= first_row_next;
      expect_filter <= expect_filter_next;
      halted        <= halted_next;
      s1_valid      <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_next) begin
      s1_err     <= s1_err_next;
      s1_filter  <= row_filter;
      s1_byte    <= s_tdata;
      s1_slot    <= slot;
      s1_left_ok <= left_ok;
      s1_up_ok   <= up_ok;
      s1_last    <= last;
      s1_addr    <= col_eff;
    end
  end

  // Reconstruction. The stage always drains into the queue, so the left and
  // upper-left bytes written here are in place for the very next byte.
  pngu_pkg::pred_in_t pin;
  logic [7:0]         value;

  always_comb begin
    pin.filter = s1_filter;
    pin.raw    = s1_byte;
    pin.a      = s1_left_ok ? left_bytes[s1_slot] : 8'd0;
    pin.c      = s1_left_ok ? upper_left_bytes[s1_slot] : 8'd0;
    pin.b      = s1_up_ok ? rd_data : 8'd0;
  end

  pngu_predict u_predict (
    .pin   (pin),
    .value (value)
  );

  assign wr_en = s1_valid && !s1_err;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[s1_addr] <= value;
    end
    if (rd_en) begin
      rd_data <= line_mem[col_eff];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      for (int i = 0; i < 4; i++) begin
        left_bytes[i]       <= 8'd0;
        upper_left_bytes[i] <= 8'd0;
      end
    end else if (wr_en) begin
      left_bytes[s1_slot]       <= value;
      upper_left_bytes[s1_slot] <= pin.b;
      if (FW'(s1_addr) >= fill) begin
        fill <= FW'(s1_addr) + FW'(1);
      end
    end
  end

  always_comb begin
    if (s1_err) begin
      push_item.pixel_byte = 8'd0;
      push_item.row_end    = 1'b0;
      push_item.bad_filter = 1'b1;
    end else begin
      push_item.pixel_byte = value;
      push_item.row_end    = s1_last;
      push_item.bad_filter = 1'b0;
    end
  end

  assign pop = m_tvalid && m_tready;

  pngu_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .count     (q_count)
  );

  assign m_tvalid   = q_count != '0;
  assign m_tdata    = head_item.pixel_byte;
  assign m_tlast    = head_item.row_end;
  assign m_tuser[0] = head_item.bad_filter;

  `PNGU_ASSERT_IMPL(a_no_rw_collide, clk, rst, wr_en && rd_en, s1_addr != col_eff, "line store read and write hit one entry")
  `PNGU_ASSERT_NEXT(a_err_halts, clk, rst, s1_valid_next && s1_err_next, halted && s1_valid && s1_err, "bad filter did not halt")
  `PNGU_ASSERT_IMPL(a_col_in_row, clk, rst, 1'b1, FW'(col) < FW'(ROW_BYTES), "column beyond line store")
  `PNGU_ASSERT_NEXT(a_data_clears_expect, clk, rst, rd_en && !last, !expect_filter, "mid-row byte ended the row")

endmodule
